>>> hdl/cigar_base_reference_placer_top_macros.svh
// ----------------------------------------------------------------------------
// cigar base reference placer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef CIGAR_BASE_REFERENCE_PLACER_TOP_MACROS_SVH
`define CIGAR_BASE_REFERENCE_PLACER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBRP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CBRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cbrp_pkg.sv
// ----------------------------------------------------------------------------
// cbrp_pkg
// types, op codes and the op kind table of the cigar base reference placer
// ----------------------------------------------------------------------------
package cbrp_pkg;

	localparam int MAX_PIECE_LEN = 63;

	// cigar op codes
	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_N  = 4'd3;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_H  = 4'd5;
	localparam logic [3:0] OP_P  = 4'd6;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	typedef struct packed {
		logic        first_op;
		logic        last_op;
		logic        empty_read;
		logic [30:0] read_pos;
		logic [30:0] read_length;
		logic [3:0]  cigar_op;
		logic [5:0]  op_len;
	} op_item_t;

	typedef struct packed {
		logic [30:0]        place_index;
		logic [31:0]        place_first;
		logic [31:0]        place_last;
		logic               last_of_read;
		logic               last_of_item;
		logic [30:0]        span_begin;
		logic signed [31:0] span_end;
	} place_item_t;

	// bit 0: consumes query, bit 1: consumes reference
	function automatic logic [1:0] op_kind(input logic [3:0] code);
		logic [1:0] k;
		case (code) inside
			OP_M, OP_EQ, OP_X: k = 2'b11;
			OP_I, OP_S:        k = 2'b01;
			OP_D, OP_N:        k = 2'b10;
			default:           k = 2'b00;
		endcase
		return k;
	endfunction

endpackage

>>> hdl/cigar_base_reference_placer_top.sv
// ----------------------------------------------------------------------------
// cigar_base_reference_placer_top
// expands cigar ops of one read into one reference place per unclipped query base
// ----------------------------------------------------------------------------
// usage:
//  - op channel (op_valid / op_stall / op_item) takes one cigar op piece per
//    item; first_op loads read_pos and read_length, last_op closes the read
//  - place channel (place_valid / place_stall / place_item) gives one place
//    per unclipped query base, plus the final place with the span on the last item
//  - one item is worked at a time; op_stall stays high from accept until
//    its last place has been loaded into the output register
//  - after accept the sequencer loads the item's places into the output
//    register one by one, then the final place if the item closes the
//    read; op_len is at most 63, and a clip item places no base
//  - the sequencer emits one place a cycle while the output is not stalled,
//    through a single shared 32-bit adder (reference step, clip sums and
//    span end all go through it)
//  - a stalled place holds in the output register and freezes the sequencer
//  - reset clears all read state to zero and leaves the block idle with no
//    place pending
// ----------------------------------------------------------------------------
module cigar_base_reference_placer_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 op_valid,
	output logic                 op_stall,
	input  cbrp_pkg::op_item_t   op_item,
	output logic                 place_valid,
	input  logic                 place_stall,
	output cbrp_pkg::place_item_t place_item
);
	import cbrp_pkg::*;

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic        state_q;

	// read state
	logic [31:0] ref_q;
	logic [30:0] held_index_q;
	logic [31:0] held_first_q;
	logic [31:0] held_last_q;
	logic [30:0] lead_q;
	logic [30:0] trail_q;
	logic        seen_q;
	logic [30:0] len_store_q;

	// per item work
	logic [5:0]  cnt_q;
	logic        adv_q;
	logic        final_q;
	logic        empty_q;

	// output register
	logic        place_valid_q;
	place_item_t place_item_q;

	// accept side decode
	logic        accept;
	logic        ld;
	logic [31:0] ref_base;
	logic [30:0] lead_base;
	logic [30:0] trail_base;
	logic        seen_base;
	logic [5:0]  len_sat;
	logic [1:0]  kind;
	logic        is_clip;
	logic [5:0]  soft_len;

	// shared adder
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_ci;
	logic [31:0] add_sum;
	logic [30:0] sat31;

	logic        out_free;

	assign op_stall    = (state_q != ST_IDLE);
	assign accept      = op_valid && (state_q == ST_IDLE);
	assign out_free    = !place_valid_q || !place_stall;
	assign place_valid = place_valid_q;
	assign place_item  = place_item_q;

	// first item of a read starts from freshly loaded state
	assign ld         = op_item.first_op || op_item.empty_read;
	assign ref_base   = ld ? {1'b0, op_item.read_pos} : ref_q;
	assign lead_base  = ld ? 31'd0 : lead_q;
	assign trail_base = ld ? 31'd0 : trail_q;
	assign seen_base  = ld ? 1'b0 : seen_q;
	assign len_sat    = (op_item.op_len > 6'(MAX_PIECE_LEN)) ? 6'(MAX_PIECE_LEN)
	                                                         : op_item.op_len;
	assign kind       = op_kind(op_item.cigar_op);
	assign is_clip    = (op_item.cigar_op == OP_S) || (op_item.cigar_op == OP_H);
	assign soft_len   = (op_item.cigar_op == OP_S) ? len_sat : 6'd0;

	// operand select for the one adder
	always_comb begin
		add_a  = ref_q;
		add_b  = 32'd0;
		add_ci = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (is_clip) begin
					// clip sum accumulate
					add_a = seen_base ? {1'b0, trail_base} : {1'b0, lead_base};
					add_b = {26'd0, soft_len};
				end else begin
					// reference-only step (deletion, skip)
					add_a = ref_base;
					add_b = {26'd0, len_sat};
				end
			end
			ST_RUN: begin
				if (cnt_q != 6'd0) begin
					// one base: reference steps if the op consumes it
					add_a = ref_q;
					add_b = {31'd0, adv_q};
				end else begin
					// span end = length - trailing soft clips
					add_a  = {1'b0, len_store_q};
					add_b  = ~{1'b0, trail_q};
					add_ci = 1'b1;
				end
			end
			default: begin
				add_a = ref_q;
			end
		endcase
	end

	assign add_sum = add_a + add_b + 32'(add_ci);
	assign sat31   = add_sum[31] ? 31'h7FFF_FFFF : add_sum[30:0];

	// sequencer and read state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ref_q        <= '0;
			held_index_q <= '0;
			held_first_q <= '0;
			held_last_q  <= '0;
			lead_q       <= '0;
			trail_q      <= '0;
			seen_q       <= 1'b0;
			len_store_q  <= '0;
			cnt_q        <= '0;
			adv_q        <= 1'b0;
			final_q      <= 1'b0;
			empty_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						adv_q   <= kind[1];
						final_q <= op_item.last_op || op_item.empty_read;
						empty_q <= op_item.empty_read;
						if (ld) begin
							held_index_q <= '0;
							held_first_q <= {1'b0, op_item.read_pos};
							len_store_q  <= op_item.read_length;
						end
						if (op_item.empty_read || is_clip) begin
							// no base places; only the clip sums may grow
							cnt_q  <= 6'd0;
							ref_q  <= ref_base;
							seen_q <= seen_base;
							if (ld) begin
								held_last_q <= {1'b0, op_item.read_pos};
							end
							if (op_item.empty_read) begin
								lead_q  <= lead_base;
								trail_q <= trail_base;
							end else if (seen_base) begin
								lead_q  <= lead_base;
								trail_q <= sat31;
							end else begin
								lead_q  <= sat31;
								trail_q <= trail_base;
							end
						end else begin
							seen_q  <= 1'b1;
							trail_q <= '0;
							lead_q  <= lead_base;
							cnt_q   <= kind[0] ? len_sat : 6'd0;
							if (!kind[0] && kind[1]) begin
								// deletion or skip stretches the held place
								ref_q       <= add_sum;
								held_last_q <= add_sum;
							end else begin
								ref_q <= ref_base;
								if (ld) begin
									held_last_q <= {1'b0, op_item.read_pos};
								end
							end
						end
					end
				end
				ST_RUN: begin
					if (out_free) begin
						if (cnt_q != 6'd0) begin
							// emit held place, open the next one
							ref_q        <= add_sum;
							held_first_q <= add_sum;
							held_last_q  <= add_sum;
							held_index_q <= held_index_q + 31'd1;
							cnt_q        <= cnt_q - 6'd1;
							if ((cnt_q == 6'd1) && !final_q) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	logic emit;
	assign emit = (state_q == ST_RUN) && out_free && ((cnt_q != 6'd0) || final_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_valid_q <= 1'b0;
		end else if (emit) begin
			place_valid_q <= 1'b1;
		end else if (!place_stall) begin
			place_valid_q <= 1'b0;
		end
	end

	// output payload, no reset
	always_ff @(posedge clk) begin
		if (emit) begin
			place_item_q.place_index <= held_index_q;
			place_item_q.place_first <= held_first_q;
			place_item_q.place_last  <= held_last_q;
			if (cnt_q != 6'd0) begin
				place_item_q.last_of_read <= 1'b0;
				place_item_q.last_of_item <= (cnt_q == 6'd1) && !final_q;
				place_item_q.span_begin   <= '0;
				place_item_q.span_end     <= '0;
			end else begin
				// final place carries the span; empty read has an empty span
				place_item_q.last_of_read <= 1'b1;
				place_item_q.last_of_item <= 1'b1;
				place_item_q.span_begin   <= empty_q ? 31'd0 : lead_q;
				place_item_q.span_end     <= empty_q ? 32'sd0 : signed'(add_sum);
			end
		end
	end

endmodule

>>> hdl/cbrp_checker.sv
// ----------------------------------------------------------------------------
// cbrp_checker
// port-level checks of the cigar base reference placer
// ----------------------------------------------------------------------------
`include "cigar_base_reference_placer_top_macros.svh"

module cbrp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  op_valid,
	input logic                  op_stall,
	input logic                  place_valid,
	input logic                  place_stall,
	input cbrp_pkg::place_item_t place_item
);
	import cbrp_pkg::*;

	// an accepted item makes the op side busy in the next cycle
	`CBRP_ASSERT_NEXT(a_busy_after_accept, op_valid && !op_stall, op_stall, "op not held busy")

	// a stalled place holds
	`CBRP_ASSERT_NEXT(a_place_hold, place_valid && place_stall,
		place_valid && $stable(place_item), "stalled place changed")

	// the read's final place always closes its item
	`CBRP_ASSERT_SAME(a_final_closes_item, place_valid && place_item.last_of_read,
		place_item.last_of_item, "final place without last_of_item")

	// span fields only on the final place
	`CBRP_ASSERT_SAME(a_span_zero, place_valid && !place_item.last_of_read,
		(place_item.span_begin == 31'd0) && (place_item.span_end == 32'sd0),
		"span set on a non-final place")

endmodule

bind cigar_base_reference_placer_top cbrp_checker u_cbrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.op_valid    (op_valid),
	.op_stall    (op_stall),
	.place_valid (place_valid),
	.place_stall (place_stall),
	.place_item  (place_item)
);
